>>> design/i2p_pkg.sv
`timescale 1ns / 1ps
// Package for the infix to postfix converter core.
// Holds stack sizing, character codes, operator classification and cell control type.
// No dependencies.

package i2p_pkg;

    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

    function automatic logic [1:0] prec_of(input logic [7:0] ch);
        logic [1:0] p;
        p = 2'd0;
        case (ch)
            CH_ASSIGN:        p = 2'd1;
            CH_PLUS, CH_MINUS: p = 2'd2;
            CH_MUL, CH_DIV:    p = 2'd3;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_op(input logic [7:0] ch);
        return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_MUL) ||
               (ch == CH_DIV) || (ch == CH_ASSIGN);
    endfunction

    function automatic logic is_operand(input logic [7:0] ch);
        return (ch >= CH_DIG_LO && ch <= CH_DIG_HI) ||
               (ch >= CH_UC_LO && ch <= CH_UC_HI) ||
               (ch >= CH_LC_LO && ch <= CH_LC_HI);
    endfunction

endpackage

>>> design/infix_to_postfix_converter_core.sv
`timescale 1ns / 1ps
// Shunting-yard infix to postfix converter: control sequencer plus a chain of stack cells.
// Depends on i2p_pkg and i2p_stack_cell.
//
//  channel | signals                                              | dir
//  in      | in_valid, in_stall, in_char, end_of_expr              | into core
//  out     | out_valid, out_stall, out_char, char_valid, last,     | out of core
//          | expr_done, overflow                                  |
//
// One transaction at a time: accept, classify, pop operators one by one, then close.
// Each pop and push shifts the whole cell chain by one place at once.
// Results pass through a one-deep pending stage so the last flag is known when sent.
// rst_n clears control state and the stack count; stack cells hold no reset value.
// out_stall holds results in place and pauses popping; in_stall is high while busy.

module infix_to_postfix_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       end_of_expr,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       last,
    output logic       expr_done,
    output logic       overflow
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_POP_RP = 3'd2;
    localparam logic [2:0] ST_POP_OP = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [7:0]                 ch_reg;
    logic                       end_reg;
    logic [i2p_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       ovf_reg, ovf_next;

    logic                       pend_valid_reg, pend_valid_next;
    logic [7:0]                 pend_char_reg;
    logic                       pend_cv_reg;
    logic                       pend_ovf_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_char_reg;
    logic                       out_cv_reg;
    logic                       out_last_reg;
    logic                       out_done_reg;
    logic                       out_ovf_reg;

    i2p_pkg::stack_ctrl_t       ctrl;
    logic [7:0]                 cell_q [i2p_pkg::STACK_DEPTH];
    logic [7:0]                 top_char;
    logic                       stack_nonempty;
    logic                       stack_full;
    logic                       out_free;
    logic                       pend_free;
    logic                       emit;
    logic [7:0]                 emit_char;
    logic                       ovf_set;
    logic                       fin_load;
    logic                       pend_to_out;
    logic [2:0]                 done_st;

    genvar gi;
    generate
        for (gi = 0; gi < i2p_pkg::STACK_DEPTH; gi++)
        begin : g_cell
            logic [7:0] above;
            logic [7:0] below;
            if (gi == 0)
            begin : g_top
                assign above = ch_reg;
            end
            else
            begin : g_mid
                assign above = cell_q[gi-1];
            end
            if (gi == i2p_pkg::STACK_DEPTH - 1)
            begin : g_bot
                assign below = cell_q[gi];
            end
            else
            begin : g_nbot
                assign below = cell_q[gi+1];
            end
            i2p_stack_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .from_above (above),
                .from_below (below),
                .entry      (cell_q[gi])
            );
        end
    endgenerate

    assign top_char       = cell_q[0];
    assign stack_nonempty = (count_reg != '0);
    assign stack_full     = (count_reg == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
    assign out_free       = !out_valid_reg || !out_stall;
    assign pend_free      = !pend_valid_reg || out_free;
    assign done_st        = end_reg ? ST_FLUSH : ST_FINISH;
    // pending result moves on when a newer one replaces it; fin_load drains it otherwise
    assign pend_to_out    = pend_valid_reg && emit;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        emit       = 1'b0;
        emit_char  = top_char;
        ovf_set    = 1'b0;
        fin_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (i2p_pkg::is_operand(ch_reg))
                begin
                    if (pend_free)
                    begin
                        emit       = 1'b1;
                        emit_char  = ch_reg;
                        state_next = done_st;
                    end
                end
                else if (ch_reg == i2p_pkg::CH_LPAREN)
                begin
                    if (stack_full)
                    begin
                        ovf_set = 1'b1;
                    end
                    else
                    begin
                        ctrl.push = 1'b1;
                    end
                    state_next = done_st;
                end
                else if (ch_reg == i2p_pkg::CH_RPAREN)
                begin
                    state_next = ST_POP_RP;
                end
                else if (i2p_pkg::is_op(ch_reg))
                begin
                    state_next = ST_POP_OP;
                end
                else
                begin
                    state_next = done_st;
                end
            end
            ST_POP_RP:
            begin
                if (stack_nonempty && (top_char != i2p_pkg::CH_LPAREN))
                begin
                    if (pend_free)
                    begin
                        emit     = 1'b1;
                        ctrl.pop = 1'b1;
                    end
                end
                else
                begin
                    ctrl.pop   = stack_nonempty;
                    state_next = done_st;
                end
            end
            ST_POP_OP:
            begin
                if (stack_nonempty &&
                    (i2p_pkg::prec_of(top_char) >= i2p_pkg::prec_of(ch_reg)))
                begin
                    if (pend_free)
                    begin
                        emit     = 1'b1;
                        ctrl.pop = 1'b1;
                    end
                end
                else
                begin
                    if (stack_full)
                    begin
                        ovf_set = 1'b1;
                    end
                    else
                    begin
                        ctrl.push = 1'b1;
                    end
                    state_next = done_st;
                end
            end
            ST_FLUSH:
            begin
                if (stack_nonempty)
                begin
                    if (pend_free)
                    begin
                        emit     = 1'b1;
                        ctrl.pop = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (pend_valid_reg || end_reg)
                begin
                    if (out_free)
                    begin
                        fin_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + i2p_pkg::CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - i2p_pkg::CNT_W'(1);
        end

        ovf_next = ovf_reg;
        if (fin_load && end_reg)
        begin
            ovf_next = 1'b0;
        end
        else if (ovf_set)
        begin
            ovf_next = 1'b1;
        end

        pend_valid_next = pend_valid_reg;
        if (emit)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_to_out || fin_load)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (pend_to_out || fin_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            ch_reg  <= in_char;
            end_reg <= end_of_expr;
        end
        if (emit)
        begin
            pend_char_reg <= emit_char;
            pend_cv_reg   <= 1'b1;
            pend_ovf_reg  <= ovf_reg;
        end
        if (pend_to_out)
        begin
            out_char_reg <= pend_char_reg;
            out_cv_reg   <= pend_cv_reg;
            out_ovf_reg  <= pend_ovf_reg;
            out_last_reg <= 1'b0;
            out_done_reg <= 1'b0;
        end
        else if (fin_load)
        begin
            out_last_reg <= 1'b1;
            if (pend_valid_reg)
            begin
                out_char_reg <= pend_char_reg;
                out_cv_reg   <= pend_cv_reg;
                out_ovf_reg  <= pend_ovf_reg;
                out_done_reg <= end_reg;
            end
            else
            begin
                // empty end marker
                out_char_reg <= 8'h00;
                out_cv_reg   <= 1'b0;
                out_ovf_reg  <= ovf_reg;
                out_done_reg <= 1'b1;
            end
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = out_cv_reg;
    assign last       = out_last_reg;
    assign expr_done  = out_done_reg;
    assign overflow   = out_ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending result left behind at end of transaction");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("expression end result not marked last");

    a_ovf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load && end_reg |=> !ovf_reg)
        else $error("overflow flag not cleared after expression end");
`endif

endmodule

>>> design/i2p_stack_cell.sv
`timescale 1ns / 1ps
// One entry of the shifting operator stack; top of stack is cell 0.
// Depends on i2p_pkg (stack_ctrl_t).

module i2p_stack_cell (
    input  logic                clk,
    input  i2p_pkg::stack_ctrl_t ctrl,
    input  logic [7:0]          from_above,
    input  logic [7:0]          from_below,
    output logic [7:0]          entry
);

    logic [7:0] entry_reg;
    logic [7:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            entry_next = from_above;
        end
        else if (ctrl.pop)
        begin
            entry_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
